/* rtl/lbc3_pkg.sv */
// Shared constants and register map for the 3D line/box clipper.
package lbc3_pkg;

	localparam int NUM_AXES  = 3;
	localparam int CODE_W    = 6;
	localparam int CFG_IDX_W = 3;

	// low-face bits of an outcode (-x, -y, -z)
	localparam logic [CODE_W-1:0] LO_FACE_BITS = 6'b010101;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_X           = 3'd0,
		REG_MIN_Y           = 3'd1,
		REG_MIN_Z           = 3'd2,
		REG_MAX_X           = 3'd3,
		REG_MAX_Y           = 3'd4,
		REG_MAX_Z           = 3'd5,
		REG_START_INSIDE_OK = 3'd6
	} cfg_reg_t;

endpackage

/* rtl/lbc3_if.sv */
// Stream interfaces of the clipper: segment in, clip result out, register writes.
interface lbc3_seg_if #(parameter int COORD_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] start_x;
	logic signed [COORD_WIDTH-1:0] start_y;
	logic signed [COORD_WIDTH-1:0] start_z;
	logic signed [COORD_WIDTH-1:0] end_x;
	logic signed [COORD_WIDTH-1:0] end_y;
	logic signed [COORD_WIDTH-1:0] end_z;

	modport source(output valid, start_x, start_y, start_z, end_x, end_y, end_z,
		input ready);
	modport sink(input valid, start_x, start_y, start_z, end_x, end_y, end_z,
		output ready);
endinterface

interface lbc3_res_if #(parameter int COORD_WIDTH = 32);
	logic valid;
	logic ready;
	logic accepted;
	logic signed [COORD_WIDTH-1:0] clip_start_x;
	logic signed [COORD_WIDTH-1:0] clip_start_y;
	logic signed [COORD_WIDTH-1:0] clip_start_z;
	logic signed [COORD_WIDTH-1:0] clip_end_x;
	logic signed [COORD_WIDTH-1:0] clip_end_y;
	logic signed [COORD_WIDTH-1:0] clip_end_z;
	logic [lbc3_pkg::CODE_W-1:0] start_code;
	logic [lbc3_pkg::CODE_W-1:0] end_code;

	modport source(output valid, accepted, clip_start_x, clip_start_y, clip_start_z,
		clip_end_x, clip_end_y, clip_end_z, start_code, end_code, input ready);
	modport sink(input valid, accepted, clip_start_x, clip_start_y, clip_start_z,
		clip_end_x, clip_end_y, clip_end_z, start_code, end_code, output ready);
endinterface

interface lbc3_cfg_if #(parameter int COORD_WIDTH = 32);
	logic valid;
	logic ready;
	logic [lbc3_pkg::CFG_IDX_W-1:0] idx;
	logic [COORD_WIDTH-1:0] data;

	modport source(output valid, idx, data, input ready);
	modport sink(input valid, idx, data, output ready);
endinterface

/* rtl/lbc3_lane.sv */
// One interpolation lane: base + num*off/den with saturation, bit-per-stage divider.
module lbc3_lane #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic [COORD_WIDTH+2:0]        adv,
	input  logic [COORD_WIDTH-1:0]        num,
	input  logic [COORD_WIDTH-1:0]        off,
	input  logic [COORD_WIDTH-1:0]        den,
	input  logic                          neg,
	input  logic signed [COORD_WIDTH-1:0] base,
	input  logic signed [COORD_WIDTH:0]   shift,
	output logic signed [COORD_WIDTH+1:0] r
);

	localparam int CW    = COORD_WIDTH;
	localparam int PW    = 2 * CW;
	localparam int NSTEP = CW - 1;
	localparam logic [CW-1:0] S_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] S_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic [CW-1:0] den;
		logic          neg;
		logic          ovf;
		logic          dz;
		logic [CW-1:0] base;
		logic [CW:0]   shift;
		logic [CW-2:0] lowp;
		logic [CW-1:0] rem;
		logic [CW-2:0] quo;
	} div_t;

	// adv[0]: product, adv[1]: overflow check, adv[2..CW]: quotient bits,
	// adv[CW+1]: saturate, adv[CW+2]: rebase
	logic [PW-1:0] prod_sm;
	logic [CW-1:0] den_sm;
	logic          neg_sm;
	logic [CW-1:0] base_sm;
	logic [CW:0]   shift_sm;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			prod_sm  <= PW'(num) * PW'(off);
			den_sm   <= den;
			neg_sm   <= neg;
			base_sm  <= base;
			shift_sm <= shift;
		end
	end

	div_t div_sd [0:NSTEP];
	logic [CW:0] top_m;

	// quotient >= 2^(CW-1) saturates anyway; otherwise the top part is the first remainder
	assign top_m = prod_sm[PW-1:CW-1];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			div_sd[0].den   <= den_sm;
			div_sd[0].neg   <= neg_sm;
			div_sd[0].ovf   <= top_m >= {1'b0, den_sm};
			div_sd[0].dz    <= den_sm == '0;
			div_sd[0].base  <= base_sm;
			div_sd[0].shift <= shift_sm;
			div_sd[0].lowp  <= prod_sm[CW-2:0];
			div_sd[0].rem   <= top_m[CW-1:0];
			div_sd[0].quo   <= '0;
		end
	end

	for (genvar j = 1; j <= NSTEP; j++) begin : g_step
		logic [CW:0] trial;
		logic [CW:0] diff;
		logic        ge;
		div_t        nxt;

		assign trial = {div_sd[j-1].rem, div_sd[j-1].lowp[CW-1-j]};
		assign ge    = trial >= {1'b0, div_sd[j-1].den};
		assign diff  = trial - {1'b0, div_sd[j-1].den};

		always_comb begin
			nxt     = div_sd[j-1];
			nxt.rem = ge ? diff[CW-1:0] : trial[CW-1:0];
			nxt.quo = {div_sd[j-1].quo[CW-3:0], ge};
		end

		always_ff @(posedge clk) begin
			if (adv[1+j])
				div_sd[j] <= nxt;
		end
	end

	div_t        fin;
	logic [CW-1:0] qs;
	logic [CW:0]   sum;
	logic [CW-1:0] sat_c;

	assign fin = div_sd[NSTEP];

	always_comb begin
		priority if (fin.dz)
			qs = '0;
		else if (fin.ovf)
			qs = fin.neg ? S_MIN : S_MAX;
		else if (fin.neg)
			qs = -{1'b0, fin.quo};
		else
			qs = {1'b0, fin.quo};
		sum = {fin.base[CW-1], fin.base} + {qs[CW-1], qs};
		priority if (!sum[CW] && sum[CW-1])
			sat_c = S_MAX;
		else if (sum[CW] && !sum[CW-1])
			sat_c = S_MIN;
		else
			sat_c = sum[CW-1:0];
	end

	logic [CW-1:0] sat_sa;
	logic [CW:0]   shift_sa;
	logic [CW+1:0] r_sb;

	always_ff @(posedge clk) begin
		if (adv[CW+1]) begin
			sat_sa   <= sat_c;
			shift_sa <= fin.shift;
		end
		if (adv[CW+2])
			r_sb <= {{2{sat_sa[CW-1]}}, sat_sa} + {shift_sa[CW], shift_sa};
	end

	assign r = r_sb;

endmodule

/* rtl/line_box_clip_3d_core.sv */
// The pipeline has COORD_WIDTH+9 register stages.
// Throughput: one segment per cycle unless the output stalls; twelve lanes
// of bit-per-stage restoring dividers set the depth, one quotient bit per stage.
// Stalls pass back combinationally; bubbles are filled while the output waits.
// Reset clears the stage valid bits, the box bounds and the start-inside flag.
module line_box_clip_3d_core #(
	parameter int COORD_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	lbc3_seg_if.sink   seg,
	lbc3_res_if.source res,
	lbc3_cfg_if.sink   cfg
);

	localparam int CW      = COORD_WIDTH;
	localparam int PW      = CW + 2;
	localparam int NA      = lbc3_pkg::NUM_AXES;
	localparam int CDW     = lbc3_pkg::CODE_W;
	localparam int NL      = CW + 3;
	localparam int S_LANE0 = 3;
	localparam int S_X     = S_LANE0 + NL;
	localparam int S_Y     = S_X + 1;
	localparam int S_Z     = S_Y + 1;
	localparam int NS      = S_Z + 1;

	typedef struct packed {
		logic [NA-1:0][CW-1:0] p1;
		logic [NA-1:0][CW-1:0] p2;
		logic [CDW-1:0]        c0;
		logic [CDW-1:0]        c1;
		logic                  rej;
	} carry_t;

	typedef struct packed {
		logic [1:0][NA-1:0][PW-1:0]       pt;
		logic [1:0][CDW-1:0]              code;
		logic                             rej;
		logic [NA-1:0][1:0][1:0][PW-1:0]  r;
	} clip_t;

	// ---------------- configuration ----------------
	logic signed [CW-1:0] box_lo_q [NA];
	logic signed [CW-1:0] box_hi_q [NA];
	logic                 sio_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NA; k++) begin
				box_lo_q[k] <= '0;
				box_hi_q[k] <= '0;
			end
			sio_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (lbc3_pkg::cfg_reg_t'(cfg.idx))
				lbc3_pkg::REG_MIN_X:           box_lo_q[0] <= cfg.data;
				lbc3_pkg::REG_MIN_Y:           box_lo_q[1] <= cfg.data;
				lbc3_pkg::REG_MIN_Z:           box_lo_q[2] <= cfg.data;
				lbc3_pkg::REG_MAX_X:           box_hi_q[0] <= cfg.data;
				lbc3_pkg::REG_MAX_Y:           box_hi_q[1] <= cfg.data;
				lbc3_pkg::REG_MAX_Z:           box_hi_q[2] <= cfg.data;
				lbc3_pkg::REG_START_INSIDE_OK: sio_q       <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// ---------------- stage valids and stall chain ----------------
	logic [NS:1]   stg_vld_q;
	logic [NS+1:1] en;
	logic [NS:1]   vld_in;

	assign en[NS+1] = res.ready;
	for (genvar i = 1; i <= NS; i++) begin : g_en
		assign en[i] = !stg_vld_q[i] || en[i+1];
	end
	assign vld_in    = {stg_vld_q[NS-1:1], seg.valid};
	assign seg.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= '0;
		end else begin
			for (int i = 1; i <= NS; i++)
				if (en[i])
					stg_vld_q[i] <= vld_in[i];
		end
	end

	// ---------------- stage 1: capture ----------------
	logic signed [CW-1:0] p1_s1 [NA];
	logic signed [CW-1:0] p2_s1 [NA];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p1_s1[0] <= seg.start_x;
			p1_s1[1] <= seg.start_y;
			p1_s1[2] <= seg.start_z;
			p2_s1[0] <= seg.end_x;
			p2_s1[1] <= seg.end_y;
			p2_s1[2] <= seg.end_z;
		end
	end

	// ---------------- stage 2: outcodes, differences, face offsets ----------------
	logic [CW:0]    dpos [NA];
	logic [CW:0]    dneg [NA];
	logic [CW:0]    opos [NA][2];
	logic [CW:0]    oneg [NA][2];
	logic [CDW-1:0] c0_c;
	logic [CDW-1:0] c1_c;
	logic           rej_c;

	always_comb begin
		c0_c = '0;
		c1_c = '0;
		for (int k = 0; k < NA; k++) begin
			dpos[k] = {p2_s1[k][CW-1], p2_s1[k]} - {p1_s1[k][CW-1], p1_s1[k]};
			dneg[k] = {p1_s1[k][CW-1], p1_s1[k]} - {p2_s1[k][CW-1], p2_s1[k]};
			opos[k][0] = {box_lo_q[k][CW-1], box_lo_q[k]} - {p1_s1[k][CW-1], p1_s1[k]};
			oneg[k][0] = {p1_s1[k][CW-1], p1_s1[k]} - {box_lo_q[k][CW-1], box_lo_q[k]};
			opos[k][1] = {box_hi_q[k][CW-1], box_hi_q[k]} - {p1_s1[k][CW-1], p1_s1[k]};
			oneg[k][1] = {p1_s1[k][CW-1], p1_s1[k]} - {box_hi_q[k][CW-1], box_hi_q[k]};
			c0_c[2*k]   = p1_s1[k] < box_lo_q[k];
			c0_c[2*k+1] = !c0_c[2*k] && (p1_s1[k] > box_hi_q[k]);
			c1_c[2*k]   = p2_s1[k] < box_lo_q[k];
			c1_c[2*k+1] = !c1_c[2*k] && (p2_s1[k] > box_hi_q[k]);
		end
		rej_c = (c0_c == '0 && !sio_q) || ((c0_c | c1_c) == '0) || ((c0_c & c1_c) != '0);
	end

	logic [CW-1:0] dm_s2   [NA];
	logic          dn_s2   [NA];
	logic [CW-1:0] offm_s2 [NA][2];
	logic          offn_s2 [NA][2];
	carry_t        cry_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int k = 0; k < NA; k++) begin
				dn_s2[k]      <= dpos[k][CW];
				dm_s2[k]      <= dpos[k][CW] ? dneg[k][CW-1:0] : dpos[k][CW-1:0];
				cry_s2.p1[k]  <= p1_s1[k];
				cry_s2.p2[k]  <= p2_s1[k];
				for (int f = 0; f < 2; f++) begin
					offn_s2[k][f] <= opos[k][f][CW];
					offm_s2[k][f] <= opos[k][f][CW] ? oneg[k][f][CW-1:0] : opos[k][f][CW-1:0];
				end
			end
			cry_s2.c0  <= c0_c;
			cry_s2.c1  <= c1_c;
			cry_s2.rej <= rej_c;
		end
	end

	// ---------------- interpolation lanes: axis k, face f, other axis m ----------------
	logic signed [PW-1:0] r_lane [NA][2][2];

	for (genvar k = 0; k < NA; k++) begin : g_ax
		for (genvar m = 0; m < 2; m++) begin : g_oth
			localparam int O = (k + 1 + m) % NA;
			logic signed [CW:0] sh_s2;

			always_ff @(posedge clk) begin
				if (en[2])
					sh_s2 <= {p1_s1[O][CW-1], p1_s1[O]} - {p1_s1[k][CW-1], p1_s1[k]};
			end

			for (genvar f = 0; f < 2; f++) begin : g_face
				lbc3_lane #(
					.COORD_WIDTH(CW)
				) u_lane (
					.clk  (clk),
					.adv  (en[S_LANE0+NL-1:S_LANE0]),
					.num  (dm_s2[O]),
					.off  (offm_s2[k][f]),
					.den  (dm_s2[k]),
					.neg  (dn_s2[O] ^ offn_s2[k][f] ^ dn_s2[k]),
					.base (cry_s2.p1[k]),
					.shift(sh_s2),
					.r    (r_lane[k][f][m])
				);
			end
		end
	end

	// segment data rides alongside the lanes
	carry_t cry_sl [1:NL];

	for (genvar j = 1; j <= NL; j++) begin : g_carry
		if (j == 1) begin : g_first
			always_ff @(posedge clk)
				if (en[S_LANE0])
					cry_sl[j] <= cry_s2;
		end else begin : g_next
			always_ff @(posedge clk)
				if (en[S_LANE0-1+j])
					cry_sl[j] <= cry_sl[j-1];
		end
	end

	// ---------------- clip stages x, y, z ----------------
	function automatic clip_t clip_axis(input clip_t a, input int k, input int o1,
		input int o2, input logic [PW-1:0] lo, input logic [PW-1:0] hi);
		clip_t b;
		b = a;
		for (int e = 0; e < 2; e++) begin
			if (!a.rej) begin
				if ($signed(a.pt[e][k]) < $signed(lo)) begin
					b.pt[e][o1] = a.r[k][0][0];
					b.pt[e][o2] = a.r[k][0][1];
					b.pt[e][k]  = lo;
					b.code[e]   = '0;
					b.code[e][2*k] = 1'b1;
				end else if ($signed(a.pt[e][k]) > $signed(hi)) begin
					b.pt[e][o1] = a.r[k][1][0];
					b.pt[e][o2] = a.r[k][1][1];
					b.pt[e][k]  = hi;
					b.code[e]   = '0;
					b.code[e][2*k+1] = 1'b1;
				end
			end
		end
		return b;
	endfunction

	logic [PW-1:0] lo_ext [NA];
	logic [PW-1:0] hi_ext [NA];
	clip_t         clp_in;

	always_comb begin
		for (int k = 0; k < NA; k++) begin
			lo_ext[k] = {{2{box_lo_q[k][CW-1]}}, box_lo_q[k]};
			hi_ext[k] = {{2{box_hi_q[k][CW-1]}}, box_hi_q[k]};
			clp_in.pt[0][k] = {{2{cry_sl[NL].p1[k][CW-1]}}, cry_sl[NL].p1[k]};
			clp_in.pt[1][k] = {{2{cry_sl[NL].p2[k][CW-1]}}, cry_sl[NL].p2[k]};
			for (int f = 0; f < 2; f++)
				for (int m = 0; m < 2; m++)
					clp_in.r[k][f][m] = r_lane[k][f][m];
		end
		clp_in.code[0] = cry_sl[NL].c0;
		clp_in.code[1] = cry_sl[NL].c1;
		clp_in.rej     = cry_sl[NL].rej;
	end

	clip_t clp_sx;
	clip_t clp_sy;
	clip_t clp_sz;

	always_ff @(posedge clk) begin
		if (en[S_X])
			clp_sx <= clip_axis(clp_in, 0, 1, 2, lo_ext[0], hi_ext[0]);
		if (en[S_Y])
			clp_sy <= clip_axis(clp_sx, 1, 2, 0, lo_ext[1], hi_ext[1]);
		if (en[S_Z])
			clp_sz <= clip_axis(clp_sy, 2, 0, 1, lo_ext[2], hi_ext[2]);
	end

	// ---------------- output register ----------------
	logic                       acc_so;
	logic [1:0][NA-1:0][CW-1:0] pt_so;
	logic [1:0][CDW-1:0]        code_so;

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			// points that clip to the same spot count as a reject
			acc_so  <= !clp_sz.rej && (clp_sz.pt[0] != clp_sz.pt[1]);
			code_so <= clp_sz.code;
			for (int e = 0; e < 2; e++)
				for (int k = 0; k < NA; k++)
					pt_so[e][k] <= clp_sz.pt[e][k][CW-1:0];
		end
	end

	assign res.valid        = stg_vld_q[NS];
	assign res.accepted     = acc_so;
	assign res.clip_start_x = pt_so[0][0];
	assign res.clip_start_y = pt_so[0][1];
	assign res.clip_start_z = pt_so[0][2];
	assign res.clip_end_x   = pt_so[1][0];
	assign res.clip_end_y   = pt_so[1][1];
	assign res.clip_end_z   = pt_so[1][2];
	assign res.start_code   = code_so[0];
	assign res.end_code     = code_so[1];

`ifndef SYNTHESIS
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		res.ready |-> seg.ready)
		else $error("input stalled while output is draining");

	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		seg.valid && seg.ready |=> stg_vld_q[1])
		else $error("accepted segment did not enter stage 1");

	a_codes_one_face: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> ((res.start_code & (res.start_code >> 1) & lbc3_pkg::LO_FACE_BITS) == '0)
			&& ((res.end_code & (res.end_code >> 1) & lbc3_pkg::LO_FACE_BITS) == '0))
		else $error("outcode flags both faces of one axis");
`endif

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the 3D line/box clipper: random and directed segments, scored.
module testbench;

	localparam int CW = 32;
	localparam longint C_HI = 64'sd2147483647;
	localparam longint C_LO = -64'sd2147483648;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic signed [CW-1:0] sx, sy, sz, ex, ey, ez;
	} segment_t;

	typedef struct {
		logic                           accepted;
		logic signed [CW-1:0]           clip_start_x, clip_start_y, clip_start_z;
		logic signed [CW-1:0]           clip_end_x, clip_end_y, clip_end_z;
		logic [lbc3_pkg::CODE_W-1:0]    start_code, end_code;
	} clip_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lbc3_seg_if #(.COORD_WIDTH(CW)) seg();
	lbc3_res_if #(.COORD_WIDTH(CW)) res();
	lbc3_cfg_if #(.COORD_WIDTH(CW)) cfg();

	line_box_clip_3d_core #(.COORD_WIDTH(CW)) u_dut (
		.clk(clk), .arst_n(arst_n), .seg(seg), .res(res), .cfg(cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// box model, updated on each config transfer
	longint box_lo[3];
	longint box_hi[3];
	bit     inside_ok;

	segment_t pending_segs[$];
	clip_t    expected_clips[$];
	segment_t cur_seg;
	int       cyc = 0;
	int       n_seg = 0, n_res = 0, n_rej = 0, n_cfg = 0;
	int       mismatches = 0;
	int       quiet = 0;
	bit       timed_out = 1'b0;

	function automatic bit calm();
		return cyc > 400 && cyc < 900;
	endfunction

	function automatic logic [63:0] mag_diff(longint p, longint q, output bit neg);
		neg = p < q;
		return neg ? 64'(q - p) : 64'(p - q);
	endfunction

	function automatic logic [63:0] scaled_quot(logic [63:0] x, logic [63:0] y, logic [63:0] d);
		logic [127:0] prod, q;
		if (d == 64'd0) return 64'd0;
		prod = {64'd0, x} * {64'd0, y};
		q = prod / {64'd0, d};
		if (q >= (128'd1 << 63)) return 64'd1 << 63;
		return q[63:0];
	endfunction

	// base + num*(face-base)/den, quotient and sum saturated to the coordinate range
	function automatic longint face_interp(logic [63:0] num, bit num_neg, longint face,
			longint base, logic [63:0] den, bit den_neg);
		bit off_neg, neg;
		logic [63:0] off, qm;
		longint q;
		off = mag_diff(face, base, off_neg);
		qm = scaled_quot(num, off, den);
		neg = num_neg ^ off_neg ^ den_neg;
		if (qm == 64'd0) q = 0;
		else if (!neg) q = (qm > 64'(C_HI)) ? C_HI : longint'(qm);
		else q = (qm >= 64'(C_HI) + 64'd1) ? C_LO : -longint'(qm);
		if (q > 0 && base > C_HI - q) return C_HI;
		if (q < 0 && base < C_LO - q) return C_LO;
		return base + q;
	endfunction

	function automatic logic [lbc3_pkg::CODE_W-1:0] outcode(longint p[3]);
		logic [lbc3_pkg::CODE_W-1:0] c;
		c = '0;
		for (int k = 0; k < 3; k++) begin
			if (p[k] < box_lo[k]) c[2*k] = 1'b1;
			else if (p[k] > box_hi[k]) c[2*k+1] = 1'b1;
		end
		return c;
	endfunction

	function automatic clip_t clip_segment(segment_t s);
		longint p1[3], pt0[3], pt1[3], pt[3], face;
		logic [63:0] dm[3];
		bit dn[3];
		logic [lbc3_pkg::CODE_W-1:0] code0, code1, code, bitv;
		int o1, o2;
		clip_t r;
		p1[0] = s.sx; p1[1] = s.sy; p1[2] = s.sz;
		pt1[0] = s.ex; pt1[1] = s.ey; pt1[2] = s.ez;
		pt0 = p1;
		code0 = outcode(pt0);
		code1 = outcode(pt1);
		r.accepted = 1'b0;
		if (!((code0 == 0 && !inside_ok) || (code0 | code1) == 0 || (code0 & code1) != 0)) begin
			for (int k = 0; k < 3; k++) dm[k] = mag_diff(pt1[k], p1[k], dn[k]);
			for (int e = 0; e < 2; e++) begin
				pt = (e == 0) ? pt0 : pt1;
				code = (e == 0) ? code0 : code1;
				for (int k = 0; k < 3; k++) begin
					o1 = (k + 1) % 3;
					o2 = (k + 2) % 3;
					bitv = '0;
					if (pt[k] < box_lo[k]) begin
						face = box_lo[k]; bitv[2*k] = 1'b1;
					end else if (pt[k] > box_hi[k]) begin
						face = box_hi[k]; bitv[2*k+1] = 1'b1;
					end
					if (bitv != 0) begin
						pt[o1] = face_interp(dm[o1], dn[o1], face, p1[k], dm[k], dn[k])
							- p1[k] + p1[o1];
						pt[o2] = face_interp(dm[o2], dn[o2], face, p1[k], dm[k], dn[k])
							- p1[k] + p1[o2];
						pt[k] = face;
						code = bitv;
					end
				end
				if (e == 0) begin
					pt0 = pt; code0 = code;
				end else begin
					pt1 = pt; code1 = code;
				end
			end
			r.accepted = !(pt0[0] == pt1[0] && pt0[1] == pt1[1] && pt0[2] == pt1[2]);
		end
		r.clip_start_x = pt0[0][CW-1:0]; r.clip_start_y = pt0[1][CW-1:0];
		r.clip_start_z = pt0[2][CW-1:0];
		r.clip_end_x = pt1[0][CW-1:0]; r.clip_end_y = pt1[1][CW-1:0];
		r.clip_end_z = pt1[2][CW-1:0];
		r.start_code = code0;
		r.end_code = code1;
		return r;
	endfunction

	// segment driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg.valid <= 1'b0;
			seg.start_x <= '0; seg.start_y <= '0; seg.start_z <= '0;
			seg.end_x <= '0; seg.end_y <= '0; seg.end_z <= '0;
		end else begin
			if (seg.valid && seg.ready) begin
				expected_clips.push_back(clip_segment(cur_seg));
				n_seg++;
			end
			if (!seg.valid || seg.ready) begin
				if (pending_segs.size() > 0 && (calm() || $urandom_range(99) >= 36)) begin
					cur_seg = pending_segs.pop_front();
					seg.valid <= 1'b1;
					seg.start_x <= cur_seg.sx; seg.start_y <= cur_seg.sy;
					seg.start_z <= cur_seg.sz;
					seg.end_x <= cur_seg.ex; seg.end_y <= cur_seg.ey;
					seg.end_z <= cur_seg.ez;
				end else begin
					seg.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		clip_t got, want;
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				got.accepted = res.accepted;
				got.clip_start_x = res.clip_start_x; got.clip_start_y = res.clip_start_y;
				got.clip_start_z = res.clip_start_z;
				got.clip_end_x = res.clip_end_x; got.clip_end_y = res.clip_end_y;
				got.clip_end_z = res.clip_end_z;
				got.start_code = res.start_code; got.end_code = res.end_code;
				n_res++;
				if (!got.accepted) n_rej++;
				if (expected_clips.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %p", got);
				end else begin
					want = expected_clips.pop_front();
					if (got.accepted !== want.accepted ||
						got.clip_start_x !== want.clip_start_x ||
						got.clip_start_y !== want.clip_start_y ||
						got.clip_start_z !== want.clip_start_z ||
						got.clip_end_x !== want.clip_end_x ||
						got.clip_end_y !== want.clip_end_y ||
						got.clip_end_z !== want.clip_end_z ||
						got.start_code !== want.start_code ||
						got.end_code !== want.end_code) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch #%0d\n  exp %p\n  got %p", n_res, want, got);
					end
				end
			end
			res.ready <= calm() || $urandom_range(99) >= 36;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		cyc++;
		if ((seg.valid && seg.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
			quiet = 0;
		else if (arst_n)
			quiet++;
		if (quiet >= WATCHDOG_LIMIT) begin
			timed_out = 1'b1;
			$display("watchdog: no transfer for %0d cycles", quiet);
			$display("[line_box_clip_3d_core] ERROR");
			$finish;
		end
	end

	task automatic write_reg(lbc3_pkg::cfg_reg_t r, longint v);
		cfg.valid <= 1'b1;
		cfg.idx <= r;
		cfg.data <= v[CW-1:0];
		do @(posedge clk); while (!cfg.ready);
		if (r == lbc3_pkg::REG_START_INSIDE_OK) inside_ok = v[0];
		else if (r < lbc3_pkg::REG_MAX_X) box_lo[r] = longint'(signed'(v[CW-1:0]));
		else box_hi[r - lbc3_pkg::REG_MAX_X] = longint'(signed'(v[CW-1:0]));
		n_cfg++;
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_box(longint lx, longint ly, longint lz, longint hx, longint hy,
			longint hz, bit ok);
		write_reg(lbc3_pkg::REG_MIN_X, lx);
		write_reg(lbc3_pkg::REG_MIN_Y, ly);
		write_reg(lbc3_pkg::REG_MIN_Z, lz);
		write_reg(lbc3_pkg::REG_MAX_X, hx);
		write_reg(lbc3_pkg::REG_MAX_Y, hy);
		write_reg(lbc3_pkg::REG_MAX_Z, hz);
		write_reg(lbc3_pkg::REG_START_INSIDE_OK, {$urandom, $urandom} & ~64'd1 | 64'(ok));
	endtask

	// hold off until every pushed segment has come back
	task automatic drain();
		do @(posedge clk);
		while (pending_segs.size() > 0 || seg.valid || expected_clips.size() > 0);
		repeat (5) @(posedge clk);
	endtask

	task automatic push_seg(longint sx, longint sy, longint sz, longint ex, longint ey,
			longint ez);
		segment_t s;
		s.sx = sx[CW-1:0]; s.sy = sy[CW-1:0]; s.sz = sz[CW-1:0];
		s.ex = ex[CW-1:0]; s.ey = ey[CW-1:0]; s.ez = ez[CW-1:0];
		pending_segs.push_back(s);
	endtask

	function automatic longint pick_coord(longint lo, longint hi);
		longint span, v;
		logic [63:0] r;
		span = hi - lo;
		if (span < 0) span = -span;
		span += 64;
		r = {$urandom, $urandom};
		case ($urandom_range(9))
			0, 1: v = longint'(signed'(r[CW-1:0]));
			2: v = lo;
			3: v = hi;
			4: v = r[0] ? lo - 1 : hi + 1;
			default: v = lo - span / 2 + longint'(r[62:0] % 64'(2 * span));
		endcase
		if (v > C_HI) v = C_HI;
		if (v < C_LO) v = C_LO;
		return v;
	endfunction

	task automatic random_segs(int n);
		longint s[3], e[3];
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 3; k++) begin
				s[k] = pick_coord(box_lo[k], box_hi[k]);
				e[k] = ($urandom_range(99) < 15) ? s[k] : pick_coord(box_lo[k], box_hi[k]);
			end
			push_seg(s[0], s[1], s[2], e[0], e[1], e[2]);
		end
	endtask

	task automatic directed_segs();
		longint u;
		u = 65536;
		push_seg(0, 0, 0, u, u, u);                          // both inside
		push_seg(0, 0, 0, 20*u, 3*u, u);                     // start inside
		push_seg(-20*u, -20*u, -20*u, 20*u, 20*u, 20*u);     // crosses all axes
		push_seg(-20*u, 0, 0, -10*u, 5*u, u);                // shared outcode bit
		push_seg(-20*u, u, u, 20*u, 2*u, -u);                // x only
		push_seg(u, -9*u, u, -u, 9*u, 2*u);                  // y only
		push_seg(u, u, -7*u, 2*u, -u, 7*u);                  // z only
		push_seg(C_HI, C_HI, C_HI, C_LO, C_LO, C_LO);
		push_seg(C_LO, 0, 0, C_HI, 0, 0);
		push_seg(C_LO, C_HI, 0, C_HI, C_LO, u);
		push_seg(8*u, 0, 0, 20*u, 0, 0);                     // clips onto its start
		push_seg(-9*u, -5*u, 0, 9*u, 7*u, 0);                // corner to corner
		push_seg(-9*u, 5*u, 0, 9*u, 5*u, 0);                 // flat in y and z
		push_seg(3*u + 12345, -3*u + 7, u/3, -30*u, 40*u, -17*u);
	endtask

	initial begin
		longint u, a, b;
		u = 65536;
		cfg.valid = 1'b0; cfg.idx = '0; cfg.data = '0;
		for (int k = 0; k < 3; k++) begin
			box_lo[k] = 0; box_hi[k] = 0;
		end
		inside_ok = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset box is a single point at the origin
		push_seg(-u, -u, -u, u, u, u);
		push_seg(0, 0, 0, u, 0, 0);
		random_segs(40);
		drain();

		set_box(-8*u, -4*u, -2*u, 8*u, 6*u, 3*u, 1'b0);
		directed_segs();
		random_segs(70);
		drain();

		set_box(-8*u, -4*u, -2*u, 8*u, 6*u, 3*u, 1'b1);
		directed_segs();
		random_segs(70);
		drain();

		set_box(C_LO, C_LO, C_LO, C_HI, C_HI, C_HI, 1'b1);
		random_segs(40);
		drain();

		// inverted box
		set_box(5*u, 2*u, u, -5*u, -2*u, -u, 1'b1);
		random_segs(40);
		drain();

		set_box(C_HI - 100, C_LO, -3, C_HI, C_LO + 100, 3, 1'b1);
		random_segs(40);
		drain();

		for (int p = 0; p < 6; p++) begin
			a = longint'(signed'(32'($urandom)));
			b = longint'(signed'(32'($urandom)));
			if (p < 3) begin
				a = $urandom_range(40) * 1000 - 20000;
				b = a + $urandom_range(1 << 20);
			end
			set_box(a, a - 7*u, a >>> 3, b, b + 9*u, b >>> 2, p[0]);
			if (p % 2 == 1) begin
				set_box(longint'(signed'(32'($urandom))), longint'(signed'(32'($urandom))),
					longint'(signed'(32'($urandom))), longint'(signed'(32'($urandom))),
					longint'(signed'(32'($urandom))), longint'(signed'(32'($urandom))),
					1'b1);
			end
			random_segs(50);
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d segments sent, %0d results checked (%0d rejected), %0d register writes",
			n_seg, n_res, n_rej, n_cfg);
		$display("boxes: reset point, mid-size, full range, inverted, edge-hugging, random");
		if (mismatches == 0 && expected_clips.size() == 0 && !timed_out) begin
			$display("[line_box_clip_3d_core] OK");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_clips.size());
			$display("[line_box_clip_3d_core] ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/lbc3_pkg.sv
rtl/lbc3_if.sv
rtl/lbc3_lane.sv
rtl/line_box_clip_3d_core.sv
sim/testbench.sv
